### sv/triangle_unit_normal_macros.svh
// Assertion macros for the triangle unit normal block.
// Used by the top level; no other dependencies.
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// implication checked on every clock, off during reset
`define TUN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TUN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/tun_pkg.sv
// Package for the triangle unit normal block: widths and stage counts.
// No dependencies.
package tun_pkg;
    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int OUT_BITS             = 16;
    localparam int MAG_BITS             = 30;
    localparam int SUM_BITS             = 62;
    localparam int ROOT_BITS            = 31;
    localparam int NRM_STAGES           = 6;
endpackage

### sv/triangle_unit_normal.sv
// Top level of the triangle unit normal block: stream ports, output skid.
// Depends on tun_pkg, tun_cross, tun_norm and the assertion macro header.
// Takes one triangle request per cycle, fully pipelined, through 3 cross product
// stages, 4 align/square/sum stages, 6 square-root and 6 divider stages and
// the output register. A one-entry skid register takes
// the result in flight when the output stalls, so s_axis_tready is registered;
// the pipe freezes only while the skid is full.
`include "triangle_unit_normal_macros.svh"
module triangle_unit_normal #(
    parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]                       m_axis_tdata,
    // degenerate
    output logic                              m_axis_tuser
);
    import tun_pkg::*;
    localparam int MW = 4 * COORD_BITS + 3;

    logic                  out_vld_reg;
    logic [3*OUT_BITS-1:0] out_dat_reg;
    logic                  out_deg_reg;
    logic                  skd_vld_reg;
    logic [3*OUT_BITS-1:0] skd_dat_reg;
    logic                  skd_deg_reg;
    logic                  out_load;
    logic                  en;
    logic                  xv;
    logic [3*MW-1:0]       xm;
    logic [2:0]            xn;
    logic                  nv;
    logic [3*OUT_BITS-1:0] nd;
    logic                  ng;

    assign en = !skd_vld_reg;
    assign s_axis_tready = en;
    assign out_load = !out_vld_reg || m_axis_tready;

    tun_cross #(.CB(COORD_BITS)) u_cross (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .in_data(s_axis_tdata[9*COORD_BITS-1:0]),
        .out_valid(xv), .out_mag(xm), .out_neg(xn)
    );

    tun_norm #(.CB(COORD_BITS), .NFB(NORMAL_FRAC_BITS)) u_norm (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(xv), .in_mag(xm), .in_neg(xn),
        .out_valid(nv), .out_nrm(nd), .out_degen(ng)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            skd_vld_reg <= 1'b0;
        end
        else if (skd_vld_reg)
        begin
            if (m_axis_tready)
                skd_vld_reg <= 1'b0;
        end
        else if (out_load)
            out_vld_reg <= nv;
        else
            skd_vld_reg <= nv;
    end

    always_ff @(posedge clk)
    begin
        if (skd_vld_reg)
        begin
            if (m_axis_tready)
            begin
                out_dat_reg <= skd_dat_reg;
                out_deg_reg <= skd_deg_reg;
            end
        end
        else if (out_load)
        begin
            out_dat_reg <= nd;
            out_deg_reg <= ng;
        end
        else
        begin
            skd_dat_reg <= nd;
            skd_deg_reg <= ng;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_dat_reg;
    assign m_axis_tuser  = out_deg_reg;

    `TUN_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TUN_ASSERT_IMP(a_degen_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `TUN_ASSERT_IMP(a_skid, skd_vld_reg, m_axis_tvalid && !s_axis_tready)
endmodule

### sv/tun_cross.sv
// Cross product front end: edge vectors, products, difference, magnitude.
// Depends on tun_pkg. Three register stages, stall by shared enable.
module tun_cross #(
    parameter int CB = tun_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [9*CB-1:0]       in_data,
    output logic                  out_valid,
    output logic [3*(4*CB+3)-1:0] out_mag,
    output logic [2:0]            out_neg
);
    import tun_pkg::*;
    localparam int DB = CB + 1;
    localparam int PB = 2 * DB;
    localparam int CW = PB + 1;
    localparam int MW = 4 * CB + 3;

    logic [2:0]            vld_reg;
    logic signed [DB-1:0]  a_reg [3];
    logic signed [DB-1:0]  b_reg [3];
    logic signed [PB-1:0]  pr_reg [6];
    logic [MW-1:0]         m_reg [3];
    logic [2:0]            n_reg;
    logic signed [CB-1:0]  p [9];
    logic signed [CW-1:0]  c [3];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            p[i] = in_data[i*CB +: CB];
        c[0] = CW'(pr_reg[0]) - CW'(pr_reg[1]);
        c[1] = CW'(pr_reg[2]) - CW'(pr_reg[3]);
        c[2] = CW'(pr_reg[4]) - CW'(pr_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= DB'(p[i]) - DB'(p[3+i]);
                b_reg[i] <= DB'(p[i]) - DB'(p[6+i]);
            end
            pr_reg[0] <= a_reg[1] * b_reg[2];
            pr_reg[1] <= b_reg[1] * a_reg[2];
            pr_reg[2] <= b_reg[0] * a_reg[2];
            pr_reg[3] <= a_reg[0] * b_reg[2];
            pr_reg[4] <= a_reg[0] * b_reg[1];
            pr_reg[5] <= b_reg[0] * a_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= c[i][CW-1];
                m_reg[i] <= c[i][CW-1] ? MW'(-c[i]) : MW'(c[i]);
            end
        end
    end

    assign out_valid = vld_reg[2];
    assign out_mag   = {m_reg[2], m_reg[1], m_reg[0]};
    assign out_neg   = n_reg;
endmodule

### sv/tun_norm.sv
// Normalizer: align to 30 bits, sum of squares, pipelined square root,
// pipelined restoring dividers. Depends on tun_pkg.
module tun_norm #(
    parameter int CB  = tun_pkg::COORD_BITS_DEF,
    parameter int NFB = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [3*(4*CB+3)-1:0] in_mag,
    input  logic [2:0]            in_neg,
    output logic                  out_valid,
    output logic [3*tun_pkg::OUT_BITS-1:0] out_nrm,
    output logic                  out_degen
);
    import tun_pkg::*;
    localparam int MW  = 4 * CB + 3;
    localparam int BLW = $clog2(MW + 1);
    localparam int QW  = NFB + 2;
    localparam int NW  = MAG_BITS + NFB + 1;
    localparam int RB  = ROOT_BITS;
    localparam int SQ_STEPS = RB;
    localparam int SQ_PER   = (SQ_STEPS + NRM_STAGES - 1) / NRM_STAGES;
    localparam int DV_PER   = (QW + NRM_STAGES - 1) / NRM_STAGES;
    localparam int NST = 4 + 2 * NRM_STAGES;

    logic [NST-1:0] vld_reg;

    // stage 1: bit length
    logic [MW-1:0]  m1_reg [3];
    logic [BLW-1:0] top1_reg;
    logic [2:0]     n1_reg;
    logic [MW-1:0]  orv;
    logic [BLW-1:0] top_c;
    always_comb
    begin
        orv = in_mag[0 +: MW] | in_mag[MW +: MW] | in_mag[2*MW +: MW];
        top_c = '0;
        for (int i = 0; i < MW; i++)
            if (orv[i])
                top_c = BLW'(i + 1);
    end

    // stage 2: alignment
    logic [MAG_BITS-1:0] m2_reg [3];
    logic [2:0]          n2_reg;
    logic                z2_reg;
    logic [MW+MAG_BITS-1:0] sh [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (top1_reg > BLW'(MAG_BITS))
                sh[i] = (MW+MAG_BITS)'(m1_reg[i]) >> (top1_reg - BLW'(MAG_BITS));
            else
                sh[i] = (MW+MAG_BITS)'(m1_reg[i]) << (BLW'(MAG_BITS) - top1_reg);
        end
    end

    // stage 3: squares
    logic [2*MAG_BITS-1:0] sq3_reg [3];
    logic [MAG_BITS-1:0]   m3_reg [3];
    logic [2:0]            n3_reg;
    logic                  z3_reg;

    // stage 4: sum
    logic [SUM_BITS-1:0]  s4_reg;
    logic [MAG_BITS-1:0]  m4_reg [3];
    logic [2:0]           n4_reg;
    logic                 z4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                m1_reg[i] <= in_mag[i*MW +: MW];
            top1_reg <= top_c;
            n1_reg   <= in_neg;
            for (int i = 0; i < 3; i++)
                m2_reg[i] <= sh[i][MAG_BITS-1:0];
            n2_reg <= n1_reg;
            z2_reg <= (top1_reg == '0);
            for (int i = 0; i < 3; i++)
            begin
                sq3_reg[i] <= m2_reg[i] * m2_reg[i];
                m3_reg[i]  <= m2_reg[i];
            end
            n3_reg <= n2_reg;
            z3_reg <= z2_reg;
            s4_reg <= SUM_BITS'(sq3_reg[0]) + SUM_BITS'(sq3_reg[1])
                    + SUM_BITS'(sq3_reg[2]);
            m4_reg <= m3_reg;
            n4_reg <= n3_reg;
            z4_reg <= z3_reg;
        end
    end

    // square root, digit by digit, SQ_PER digits per stage
    logic [SUM_BITS-1:0] sr_rem_reg [NRM_STAGES];
    logic [RB-1:0]       sr_root_reg [NRM_STAGES];
    logic [SUM_BITS-1:0] sr_n_reg   [NRM_STAGES];
    logic [MAG_BITS-1:0] sr_m_reg   [NRM_STAGES][3];
    logic [2:0]          sr_neg_reg [NRM_STAGES];
    logic                sr_z_reg   [NRM_STAGES];
    logic [SUM_BITS-1:0] sr_rem_c  [NRM_STAGES];
    logic [RB-1:0]       sr_root_c [NRM_STAGES];
    logic [SUM_BITS-1:0] sr_n_c    [NRM_STAGES];

    always_comb
    begin
        logic [SUM_BITS-1:0] rem;
        logic [RB-1:0]       root;
        logic [SUM_BITS-1:0] nn;
        logic [SUM_BITS+1:0] trial;
        logic [SUM_BITS+1:0] rr;
        for (int s = 0; s < NRM_STAGES; s++)
        begin
            rem  = (s == 0) ? '0 : sr_rem_reg[s-1];
            root = (s == 0) ? '0 : sr_root_reg[s-1];
            nn   = (s == 0) ? s4_reg : sr_n_reg[s-1];
            for (int k = 0; k < SQ_PER; k++)
            begin
                if (s * SQ_PER + k < SQ_STEPS)
                begin
                    rr    = {rem, nn[SUM_BITS-1 -: 2]};
                    trial = (SUM_BITS+2)'({root, 2'b01});
                    nn    = {nn[SUM_BITS-3:0], 2'b00};
                    if (rr >= trial)
                    begin
                        rem  = SUM_BITS'(rr - trial);
                        root = {root[RB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem  = SUM_BITS'(rr);
                        root = {root[RB-2:0], 1'b0};
                    end
                end
            end
            sr_rem_c[s]  = rem;
            sr_root_c[s] = root;
            sr_n_c[s]    = nn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_m_reg[0]   <= m4_reg;
            sr_neg_reg[0] <= n4_reg;
            sr_z_reg[0]   <= z4_reg;
            for (int s = 0; s < NRM_STAGES; s++)
            begin
                sr_rem_reg[s]  <= sr_rem_c[s];
                sr_root_reg[s] <= sr_root_c[s];
                sr_n_reg[s]    <= sr_n_c[s];
            end
            for (int s = 1; s < NRM_STAGES; s++)
            begin
                sr_m_reg[s]    <= sr_m_reg[s-1];
                sr_neg_reg[s]  <= sr_neg_reg[s-1];
                sr_z_reg[s]    <= sr_z_reg[s-1];
            end
        end
    end

    // three restoring dividers, DV_PER quotient bits per stage
    logic [RB-1:0]  len_w;
    assign len_w = (sr_root_reg[NRM_STAGES-1] == '0) ? RB'(1) : sr_root_reg[NRM_STAGES-1];
    logic [NW-1:0]  dv_num_reg [NRM_STAGES][3];
    logic [RB:0]    dv_rem_reg [NRM_STAGES][3];
    logic [QW-1:0]  dv_q_reg   [NRM_STAGES][3];
    logic [RB-1:0]  dv_d_reg   [NRM_STAGES];
    logic [2:0]     dv_neg_reg [NRM_STAGES];
    logic           dv_z_reg   [NRM_STAGES];
    logic [NW-1:0]  dv_num_c [NRM_STAGES][3];
    logic [RB:0]    dv_rem_c [NRM_STAGES][3];
    logic [QW-1:0]  dv_q_c   [NRM_STAGES][3];

    always_comb
    begin
        logic [NW-1:0] num;
        logic [RB:0]   rem;
        logic [QW-1:0] q;
        logic [RB-1:0] d;
        logic [RB+1:0] t;
        for (int s = 0; s < NRM_STAGES; s++)
        begin
            d = (s == 0) ? len_w : dv_d_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                if (s == 0)
                begin
                    // quotient fits QW bits, so the upper numerator bits seed the remainder
                    num = (NW'(sr_m_reg[NRM_STAGES-1][i]) << NFB) + NW'(len_w >> 1);
                    rem = (RB+1)'(num >> QW);
                    num = num << (NW - QW);
                    q   = '0;
                end
                else
                begin
                    num = dv_num_reg[s-1][i];
                    rem = dv_rem_reg[s-1][i];
                    q   = dv_q_reg[s-1][i];
                end
                for (int k = 0; k < DV_PER; k++)
                begin
                    if (s * DV_PER + k < QW)
                    begin
                        t   = {rem, num[NW-1]};
                        num = {num[NW-2:0], 1'b0};
                        if (t >= (RB+2)'(d))
                        begin
                            rem = (RB+1)'(t - (RB+2)'(d));
                            q   = {q[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem = (RB+1)'(t);
                            q   = {q[QW-2:0], 1'b0};
                        end
                    end
                end
                dv_num_c[s][i] = num;
                dv_rem_c[s][i] = rem;
                dv_q_c[s][i]   = q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NRM_STAGES; s++)
            begin
                dv_num_reg[s] <= dv_num_c[s];
                dv_rem_reg[s] <= dv_rem_c[s];
                dv_q_reg[s]   <= dv_q_c[s];
                dv_d_reg[s]   <= (s == 0) ? len_w : dv_d_reg[s-1];
                dv_neg_reg[s] <= (s == 0) ? sr_neg_reg[NRM_STAGES-1] : dv_neg_reg[s-1];
                dv_z_reg[s]   <= (s == 0) ? sr_z_reg[NRM_STAGES-1] : dv_z_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    logic [OUT_BITS-1:0] res [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res[i] = OUT_BITS'(dv_q_reg[NRM_STAGES-1][i]);
            if (dv_z_reg[NRM_STAGES-1])
                res[i] = '0;
            else if (dv_neg_reg[NRM_STAGES-1][i])
                res[i] = -res[i];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_nrm   = {res[2], res[1], res[0]};
    assign out_degen = dv_z_reg[NRM_STAGES-1];
endmodule
